@@ hdl/sorted_list_table_assert.svh @@
// ----------------------------------------------------------------------------
// sorted_list_table_assert
// assertion macros used by the checker file of the sorted list table
// ----------------------------------------------------------------------------
`ifndef SORTED_LIST_TABLE_ASSERT_SVH
`define SORTED_LIST_TABLE_ASSERT_SVH

// a holds at this edge, so b holds at the same edge
`define SLT_ASSERT_NOW(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("sorted_list_table assertion failed");

// a holds at this edge, so b holds at the next edge
`define SLT_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("sorted_list_table assertion failed");

`endif

@@ hdl/slt_pkg.sv @@
// ----------------------------------------------------------------------------
// slt_pkg
// shared types and codes of the sorted list table
// ----------------------------------------------------------------------------
package slt_pkg;

  // input commands
  localparam logic [1:0] CMD_INSERT  = 2'd0;
  localparam logic [1:0] CMD_DELETE  = 2'd1;
  localparam logic [1:0] CMD_DISPLAY = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  // configuration register index and reset value
  localparam logic       REG_LIST_SIZE   = 1'b0;
  localparam logic [5:0] LIST_SIZE_RESET = 6'd32;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_DEL_CMP,
    S_DEL_SH,
    S_DISP,
    S_RESP
  } state_t;

endpackage

@@ hdl/slt_ram.sv @@
// ----------------------------------------------------------------------------
// slt_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module slt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds while no read is issued
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/slt_cfg.sv @@
// ----------------------------------------------------------------------------
// slt_cfg
// apb register block holding the list size limit
// ----------------------------------------------------------------------------
module slt_cfg (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [5:0]  list_size
);

  import slt_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_LIST_SIZE);

  always_ff @(posedge clk) begin
    if (rst) begin
      list_size <= LIST_SIZE_RESET;
    end else if (wr_en) begin
      list_size <= pwdata[5:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_LIST_SIZE) begin
      prdata = {26'd0, list_size};
    end
  end

endmodule

@@ hdl/slt_ctrl.sv @@
// ----------------------------------------------------------------------------
// slt_ctrl
// sequencer that walks the entry memory for insert, delete and display
// ----------------------------------------------------------------------------
module slt_ctrl #(
  parameter int CAPACITY = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [5:0]         list_size,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         command,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic signed [31:0] element,
  output logic               has_element,
  output logic               last
);

  import slt_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  state_t state, state_next;

  logic [CW-1:0]      idx, idx_next;
  logic [CW-1:0]      cnt, cnt_next;
  logic signed [31:0] val, val_next;
  logic [1:0]         rsp, rsp_next;

  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wdata, rdata;

  logic          load_out;
  logic [1:0]    ld_status;
  logic [31:0]   ld_element;
  logic          ld_has, ld_last;

  logic          acc, slot_free, full;
  logic          gt, lt, ne;
  logic [CW-1:0] inc1, inc2, dec1, dec2;

  slt_ram #(
    .WIDTH (32),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign in_stall  = (state != S_IDLE);
  assign acc       = in_valid && !in_stall;
  assign slot_free = !out_valid || !out_stall;

  assign full = (8'(cnt) >= 8'(list_size)) || (cnt >= CW'(CAPACITY));

  assign gt = $signed(rdata) > val;
  assign lt = $signed(rdata) < val;
  assign ne = $signed(rdata) != val;

  assign inc1 = idx + CW'(1);
  assign inc2 = idx + CW'(2);
  assign dec1 = idx - CW'(1);
  assign dec2 = idx - CW'(2);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (acc) begin
          case (command)
            CMD_INSERT:  state_next = full ? S_RESP : S_INS_RD;
            CMD_DELETE:  state_next = (cnt == '0) ? S_RESP : S_DEL_CMP;
            CMD_DISPLAY: state_next = (cnt == '0) ? S_RESP : S_DISP;
            default:     state_next = S_IDLE;
          endcase
        end
      end
      S_INS_RD: begin
        state_next = (idx == '0) ? S_RESP : S_INS_CMP;
      end
      S_INS_CMP: begin
        if (!gt) begin
          state_next = S_RESP;
        end else if (idx == CW'(1)) begin
          state_next = S_INS_RD;
        end
      end
      S_DEL_CMP: begin
        if (lt) begin
          if (inc1 >= cnt) state_next = S_RESP;
        end else if (ne || inc1 >= cnt) begin
          state_next = S_RESP;
        end else begin
          state_next = S_DEL_SH;
        end
      end
      S_DEL_SH: begin
        if (inc2 >= cnt) state_next = S_RESP;
      end
      S_DISP: begin
        if (slot_free && inc1 == cnt) state_next = S_IDLE;
      end
      S_RESP: begin
        if (slot_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // memory access, counters and result loading
  always_comb begin
    we         = 1'b0;
    waddr      = idx[AW-1:0];
    wdata      = val;
    re         = 1'b0;
    raddr      = '0;
    idx_next   = idx;
    cnt_next   = cnt;
    val_next   = val;
    rsp_next   = rsp;
    load_out   = 1'b0;
    ld_status  = ST_OK;
    ld_element = '0;
    ld_has     = 1'b0;
    ld_last    = 1'b1;
    case (state)
      S_IDLE: begin
        if (acc) begin
          val_next = value;
          idx_next = '0;
          case (command)
            CMD_INSERT: begin
              if (full) rsp_next = ST_FULL;
              else      idx_next = cnt;
            end
            CMD_DELETE, CMD_DISPLAY: begin
              if (cnt == '0) begin
                rsp_next = ST_EMPTY;
              end else begin
                re = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      S_INS_RD: begin
        if (idx == '0) begin
          we       = 1'b1;
          cnt_next = cnt + CW'(1);
          rsp_next = ST_OK;
        end else begin
          re    = 1'b1;
          raddr = dec1[AW-1:0];
        end
      end
      S_INS_CMP: begin
        we = 1'b1;
        if (gt) begin
          // move the larger entry up one slot, read the next one down
          wdata    = rdata;
          idx_next = dec1;
          if (idx != CW'(1)) begin
            re    = 1'b1;
            raddr = dec2[AW-1:0];
          end
        end else begin
          cnt_next = cnt + CW'(1);
          rsp_next = ST_OK;
        end
      end
      S_DEL_CMP: begin
        if (lt) begin
          idx_next = inc1;
          if (inc1 >= cnt) begin
            rsp_next = ST_NOTFOUND;
          end else begin
            re    = 1'b1;
            raddr = inc1[AW-1:0];
          end
        end else if (ne) begin
          rsp_next = ST_NOTFOUND;
        end else if (inc1 >= cnt) begin
          cnt_next = cnt - CW'(1);
          rsp_next = ST_OK;
        end else begin
          re    = 1'b1;
          raddr = inc1[AW-1:0];
        end
      end
      S_DEL_SH: begin
        // close the gap: entry above moves down into slot idx
        we       = 1'b1;
        wdata    = rdata;
        idx_next = inc1;
        if (inc2 >= cnt) begin
          cnt_next = cnt - CW'(1);
          rsp_next = ST_OK;
        end else begin
          re    = 1'b1;
          raddr = inc2[AW-1:0];
        end
      end
      S_DISP: begin
        if (slot_free) begin
          load_out   = 1'b1;
          ld_element = rdata;
          ld_has     = 1'b1;
          ld_last    = (inc1 == cnt);
          idx_next   = inc1;
          if (inc1 != cnt) begin
            re    = 1'b1;
            raddr = inc1[AW-1:0];
          end
        end
      end
      S_RESP: begin
        if (slot_free) begin
          load_out  = 1'b1;
          ld_status = rsp;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    val <= val_next;
    rsp <= rsp_next;
  end

  // output register, parts the sequencer from the result channel
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      status      <= ld_status;
      element     <= ld_element;
      has_element <= ld_has;
      last        <= ld_last;
    end
  end

endmodule

@@ hdl/sorted_list_table.sv @@
// ----------------------------------------------------------------------------
// sorted_list_table
// ascending table of signed 32-bit values with insert, delete and display
// ----------------------------------------------------------------------------
// The table takes one command at a time; in_stall stays high until the
// command's work in the entry memory is done and its last result is loaded.
// An insert moves each entry larger than the value up one slot, a delete
// walks up to the first entry not below the value and, if it matches, moves
// every entry above it down, a display sends every entry held, and a rejected
// command (full, empty) goes straight to its result. Their pace is set by the
// single read and single write port of the entry memory, one entry moved or
// compared per cycle, and one sent per cycle while the result side does not
// stall. Results leave through an output register, so a new command is taken
// while the last result still waits.
module sorted_list_table #(
  parameter int CAPACITY = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         command,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic signed [31:0] element,
  output logic               has_element,
  output logic               last
);

  logic [5:0] list_size;

  slt_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .list_size (list_size)
  );

  slt_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .list_size   (list_size),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .command     (command),
    .value       (value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .element     (element),
    .has_element (has_element),
    .last        (last)
  );

endmodule

@@ hdl/slt_checker.sv @@
// ----------------------------------------------------------------------------
// slt_checker
// port-level checks on the result channel of the sorted list table
// ----------------------------------------------------------------------------
`include "sorted_list_table_assert.svh"

module slt_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input logic [1:0]         status,
  input logic signed [31:0] element,
  input logic               has_element,
  input logic               last
);

  import slt_pkg::*;

  // a stalled result transfer keeps its payload
  `SLT_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall,
    out_valid && $stable(status) && $stable(element) && $stable(has_element) && $stable(last))

  // a result without an entry carries a zero element
  `SLT_ASSERT_NOW(a_elem_zero, clk, rst, out_valid && !has_element, element == 32'sd0)

  // status-only results always close their command
  `SLT_ASSERT_NOW(a_status_last, clk, rst, out_valid && !has_element, last)

  // an error status never comes with a displayed entry
  `SLT_ASSERT_NOW(a_err_no_elem, clk, rst, out_valid && status != ST_OK, !has_element)

endmodule

bind sorted_list_table slt_checker u_slt_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .status      (status),
  .element     (element),
  .has_element (has_element),
  .last        (last)
);

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the sorted list table: directed corner cases, then
// random command phases under several list sizes, with random gaps and stalls
// on both streams; every result is checked against an in-bench table model
// ----------------------------------------------------------------------------
module tb_top;
  import slt_pkg::*;

  localparam int          CAPACITY       = 32;
  localparam logic [1:0]  CMD_UNUSED     = 2'd3;
  localparam logic [2:0]  ADDR_LIST_SIZE = 3'(4 * REG_LIST_SIZE);
  localparam logic [2:0]  ADDR_UNMAPPED  = 3'd4;
  localparam int          SETTLE_CYCLES  = CAPACITY + 12;
  localparam int          CYCLE_LIMIT    = 600000;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] element;
    logic               has_element;
    logic               last;
  } result_t;

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         command;
  logic signed [31:0] value;
  logic               out_valid;
  logic               out_stall;
  logic [1:0]         status;
  logic signed [31:0] element;
  logic               has_element;
  logic               last;

  // table model
  logic signed [31:0] kept [CAPACITY];
  int unsigned        kept_count;
  logic [5:0]         size_reg;
  result_t            expected_results[$];

  int  errors;
  int  cycles;
  bit  tx_no_idle;
  bit  rx_no_idle;

  sorted_list_table #(
    .CAPACITY(CAPACITY)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .command    (command),
    .value      (value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .element    (element),
    .has_element(has_element),
    .last       (last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at cycle %0d: %s got %0h expected %0h", cycles, what, got, want);
    errors++;
  endtask

  // ---------------------------------------------------------------- predictor
  function automatic void push_result(logic [1:0] st, logic signed [31:0] elem,
                                      logic has, logic fin);
    result_t r;
    r.status      = st;
    r.element     = elem;
    r.has_element = has;
    r.last        = fin;
    expected_results.push_back(r);
  endfunction

  function automatic void apply_command(logic [1:0] cmd, logic signed [31:0] val);
    int unsigned limit;
    int unsigned i;
    limit = (size_reg < CAPACITY) ? size_reg : CAPACITY;
    case (cmd)
      CMD_INSERT: begin
        if (kept_count >= limit) begin
          push_result(ST_FULL, '0, 1'b0, 1'b1);
        end else begin
          // equal entries stay below the new one
          i = kept_count;
          while (i > 0 && kept[i-1] > val) begin
            kept[i] = kept[i-1];
            i--;
          end
          kept[i] = val;
          kept_count++;
          push_result(ST_OK, '0, 1'b0, 1'b1);
        end
      end
      CMD_DELETE: begin
        if (kept_count == 0) begin
          push_result(ST_EMPTY, '0, 1'b0, 1'b1);
        end else begin
          i = 0;
          while (i < kept_count && kept[i] < val) i++;
          if (i >= kept_count || kept[i] != val) begin
            push_result(ST_NOTFOUND, '0, 1'b0, 1'b1);
          end else begin
            while (i + 1 < kept_count) begin
              kept[i] = kept[i+1];
              i++;
            end
            kept_count--;
            push_result(ST_OK, '0, 1'b0, 1'b1);
          end
        end
      end
      CMD_DISPLAY: begin
        if (kept_count == 0) begin
          push_result(ST_EMPTY, '0, 1'b0, 1'b1);
        end else begin
          for (i = 0; i < kept_count; i++)
            push_result(ST_OK, kept[i], 1'b1, i + 1 == kept_count);
        end
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------- checker
  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result status", status, '0);
      end else begin
        want = expected_results.pop_front();
        if (status !== want.status) report_mismatch("status", status, want.status);
        if (element !== want.element) report_mismatch("element", element, want.element);
        if (has_element !== want.has_element)
          report_mismatch("has_element", has_element, want.has_element);
        if (last !== want.last) report_mismatch("last", last, want.last);
      end
    end
  end

  // result side stall: a random hold-off before each transfer
  initial begin
    int wait_cycles;
    out_stall = 1'b1;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 15) == 0) rx_no_idle = ~rx_no_idle;
      wait_cycles = rx_no_idle ? 0 : $urandom_range(0, 11);
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // ---------------------------------------------------------------- drivers
  task automatic send_item(input logic [1:0] cmd, input logic signed [31:0] val);
    int gap;
    if ($urandom_range(0, 15) == 0) tx_no_idle = ~tx_no_idle;
    gap = tx_no_idle ? 0 : $urandom_range(0, 11);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    value    <= val;
    do @(posedge clk); while (in_stall);
    apply_command(cmd, val);
  endtask

  task automatic wait_results_done();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_LIST_SIZE) size_reg = data[5:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_list_size_reg();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_LIST_SIZE;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {26'd0, size_reg}) report_mismatch("list_size readback", prdata, size_reg);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // only between phases: no result pending and the block given time to settle
  task automatic set_list_size(input logic [5:0] size);
    wait_results_done();
    repeat (SETTLE_CYCLES) @(posedge clk);
    apb_write(ADDR_LIST_SIZE, {26'($urandom_range(0, 32'h03ff_ffff)), size});
    check_list_size_reg();
  endtask

  // biased toward stored values and small numbers so deletes hit and duplicates form
  function automatic logic signed [31:0] pick_value();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel <= 2 && kept_count > 0) return kept[$urandom_range(0, kept_count - 1)];
    if (sel <= 5) return $signed($urandom_range(0, 16)) - 8;
    if (sel == 6) begin
      case ($urandom_range(0, 3))
        0: return 32'sh7fff_ffff;
        1: return 32'sh8000_0000;
        2: return 32'sh0000_0000;
        default: return -32'sd1;
      endcase
    end
    return $urandom;
  endfunction

  // ---------------------------------------------------------------- tests
  task automatic test_empty_table();
    check_list_size_reg();
    send_item(CMD_DISPLAY, 32'sd5);
    send_item(CMD_DELETE, 32'sd0);
  endtask

  task automatic test_extremes();
    send_item(CMD_INSERT, 32'sh7fff_ffff);
    send_item(CMD_INSERT, 32'sh8000_0000);
    send_item(CMD_INSERT, 32'sd0);
    send_item(CMD_INSERT, -32'sd1);
    send_item(CMD_INSERT, 32'sd0);
    send_item(CMD_INSERT, 32'sh7fff_ffff);
    send_item(CMD_DISPLAY, 32'sh5555_aaaa);
    send_item(CMD_DELETE, 32'sd7);
    send_item(CMD_DELETE, 32'sh8000_0000);
    send_item(CMD_DELETE, 32'sh7fff_ffff);
    send_item(CMD_DISPLAY, '0);
  endtask

  task automatic test_unused_command();
    send_item(CMD_UNUSED, 32'sh7fff_ffff);
    send_item(CMD_UNUSED, 32'sh8000_0000);
    send_item(CMD_DISPLAY, '0);
  endtask

  task automatic test_unmapped_register();
    wait_results_done();
    repeat (SETTLE_CYCLES) @(posedge clk);
    apb_write(ADDR_UNMAPPED, 32'h0000_0001);
    check_list_size_reg();
    send_item(CMD_INSERT, 32'sd3);
  endtask

  // limit dropped under the number of held entries
  task automatic test_lowered_limit();
    set_list_size(6'd2);
    send_item(CMD_INSERT, 32'sd9);
    send_item(CMD_DISPLAY, '0);
    send_item(CMD_DELETE, 32'sd0);
    send_item(CMD_INSERT, 32'sd1);
  endtask

  task automatic test_zero_size();
    set_list_size(6'd0);
    send_item(CMD_INSERT, -32'sd4);
    send_item(CMD_DELETE, -32'sd1);
  endtask

  task automatic test_random_phase(input logic [5:0] size, input int items,
                                   input int insert_pct, input bit pause_midway);
    int roll;
    logic [1:0] cmd;
    set_list_size(size);
    for (int n = 0; n < items; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < insert_pct) cmd = CMD_INSERT;
      else if (roll < insert_pct + (100 - insert_pct) * 6 / 10) cmd = CMD_DELETE;
      else if (roll < 95) cmd = CMD_DISPLAY;
      else cmd = CMD_UNUSED;
      send_item(cmd, pick_value());
      if (pause_midway && n == items / 2) wait_results_done();
    end
  endtask

  // ---------------------------------------------------------------- sequence
  initial begin
    errors     = 0;
    cycles     = 0;
    tx_no_idle = 1'b0;
    rx_no_idle = 1'b0;
    kept_count = 0;
    size_reg   = LIST_SIZE_RESET;
    rst        = 1'b1;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    in_valid   = 1'b0;
    command    = CMD_INSERT;
    value      = '0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    test_empty_table();
    test_extremes();
    test_unused_command();
    test_unmapped_register();
    test_lowered_limit();
    test_zero_size();

    test_random_phase(6'd63, 37, 75, 1'b0);
    test_random_phase(6'd32, 45, 50, 1'b1);
    test_random_phase(6'd1, 30, 50, 1'b0);
    test_random_phase(6'd7, 40, 55, 1'b0);
    test_random_phase(6'($urandom_range(1, 63)), 40, 50, 1'b0);
    test_random_phase(6'd0, 15, 50, 1'b0);
    test_random_phase(6'd32, 40, 30, 1'b0);

    wait_results_done();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      report_mismatch("results never delivered", expected_results.size(), 0);
    end
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
